// ===== design/fws_pkg.sv =====
// Shared types, constants and state codes of the fewest-words segmenter.
`timescale 1ns / 1ps
`default_nettype none
package fws_pkg;

    localparam int MAX_LEN_DEF = 64;

    localparam int START_W = 6;
    localparam int LEN_W   = 7;
    localparam int TOK_W   = 32;
    localparam int CNT_W   = 7;

    localparam logic [CNT_W-1:0] COUNT_INF = 7'd127;

    localparam logic FUNC_EDGE   = 1'b0;
    localparam logic FUNC_FINISH = 1'b1;

    typedef struct packed {
        logic               func;
        logic [START_W-1:0] edge_start;
        logic [LEN_W-1:0]   edge_len;
        logic               found;
        logic [TOK_W-1:0]   word_token;
        logic [LEN_W-1:0]   sentence_len;
    } t_in_beat;

    typedef struct packed {
        logic [START_W-1:0] seg_start;
        logic [LEN_W-1:0]   seg_len;
        logic [TOK_W-1:0]   seg_token;
        logic               last;
    } t_out_beat;

    // One segment found by the back-pointer walk.
    typedef struct packed {
        logic [START_W-1:0] start;
        logic [LEN_W-1:0]   len;
        logic [TOK_W-1:0]   token;
    } t_seg;

    // Back-pointer entry of one position.
    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic [TOK_W-1:0] token;
    } t_link;

    // Commands from the sequencer to the position store.
    typedef struct packed {
        logic edge_go;
        logic walk_rd;
        logic clear;
    } t_store_ctl;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EDGE,
        S_WALK,
        S_EMIT
    } t_state;

endpackage
`default_nettype wire

// ===== design/fws_in_if.sv =====
// Input channel of the segmenter: edge and finish beats.
`timescale 1ns / 1ps
`default_nettype none
interface fws_in_if;
    logic              valid;
    logic              ready;
    fws_pkg::t_in_beat data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== design/fws_out_if.sv =====
// Output channel of the segmenter: one beat per emitted segment.
`timescale 1ns / 1ps
`default_nettype none
interface fws_out_if;
    logic               valid;
    logic               ready;
    fws_pkg::t_out_beat data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== design/fws_store.sv =====
// Position store: word counts and back-pointers with read-modify-write edge update.
`timescale 1ns / 1ps
`default_nettype none
module fws_store #(
    parameter int MAX_LEN = fws_pkg::MAX_LEN_DEF,
    localparam int DEPTH  = MAX_LEN + 1,
    localparam int POS_W  = $clog2(DEPTH)
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire fws_pkg::t_store_ctl  i_ctl,
    input  wire fws_pkg::t_in_beat    i_beat,
    input  wire logic [POS_W-1:0]     i_walk_addr,
    output fws_pkg::t_link            o_link
);

    localparam int CNT_W = fws_pkg::CNT_W;
    localparam int LEN_W = fws_pkg::LEN_W;
    localparam int TOK_W = fws_pkg::TOK_W;

    logic [CNT_W-1:0]     r_cnt_mem [DEPTH];
    fws_pkg::t_link       r_lnk_mem [DEPTH];
    logic [DEPTH-1:0]     r_vld;

    // Edge decode in the accept cycle.
    logic [LEN_W:0]       n_end_sum;
    logic                 n_use;
    logic [POS_W-1:0]     n_start_a;
    logic [POS_W-1:0]     n_end_a;

    // Registered edge and read data for the update cycle.
    logic                 r_upd;
    logic                 r_use;
    logic [POS_W-1:0]     r_end;
    logic [LEN_W-1:0]     r_len;
    logic [TOK_W-1:0]     r_tok;
    logic                 r_s_zero;
    logic                 r_s_vld;
    logic                 r_e_vld;
    logic [CNT_W-1:0]     r_cs_raw;
    logic [CNT_W-1:0]     r_ce_raw;

    logic [CNT_W-1:0]     n_cs;
    logic [CNT_W-1:0]     n_ce;
    logic [CNT_W-1:0]     n_cnt;
    logic                 n_wr;

    fws_pkg::t_link       r_w_data;
    logic                 r_w_vld;

    assign n_end_sum = {1'b0, i_beat.edge_len} + (LEN_W+1)'(i_beat.edge_start);
    assign n_use     = (i_beat.edge_len != '0)
                    && (n_end_sum <= (LEN_W+1)'(MAX_LEN))
                    && (i_beat.found || (i_beat.edge_len == LEN_W'(1)));
    assign n_start_a = POS_W'(i_beat.edge_start);
    assign n_end_a   = n_end_sum[POS_W-1:0];

    // Position 0 always costs nothing; an unwritten position is unreached.
    assign n_cs  = r_s_zero ? '0 : (r_s_vld ? r_cs_raw : fws_pkg::COUNT_INF);
    assign n_ce  = r_e_vld ? r_ce_raw : fws_pkg::COUNT_INF;
    assign n_cnt = (n_cs == fws_pkg::COUNT_INF) ? fws_pkg::COUNT_INF : n_cs + CNT_W'(1);
    assign n_wr  = r_upd && r_use && (n_cnt < n_ce);

    always_ff @(posedge i_clk) begin
        if (i_ctl.edge_go) begin
            r_cs_raw <= r_cnt_mem[n_start_a];
            r_ce_raw <= r_cnt_mem[n_end_a];
            r_s_vld  <= r_vld[n_start_a];
            r_e_vld  <= r_vld[n_end_a];
            r_s_zero <= (i_beat.edge_start == '0);
            r_use    <= n_use;
            r_end    <= n_end_a;
            r_len    <= i_beat.edge_len;
            r_tok    <= i_beat.found ? i_beat.word_token : '0;
        end
        if (n_wr) begin
            r_cnt_mem[r_end] <= n_cnt;
            r_lnk_mem[r_end] <= '{len: r_len, token: r_tok};
        end
        if (i_ctl.walk_rd) begin
            r_w_data <= r_lnk_mem[i_walk_addr];
            r_w_vld  <= r_vld[i_walk_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upd <= 1'b0;
            r_vld <= '0;
        end else begin
            r_upd <= i_ctl.edge_go;
            if (i_ctl.clear) begin
                r_vld <= '0;
            end else if (n_wr) begin
                r_vld[r_end] <= 1'b1;
            end
        end
    end

    assign o_link = r_w_vld ? r_w_data : '0;

endmodule
`default_nettype wire

// ===== design/fws_path.sv =====
// Path stack: holds the walked segments and plays them out in forward order.
`timescale 1ns / 1ps
`default_nettype none
module fws_path #(
    parameter int MAX_LEN = fws_pkg::MAX_LEN_DEF,
    localparam int POS_W  = $clog2(MAX_LEN + 1),
    localparam int IDX_W  = $clog2(MAX_LEN)
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire logic [IDX_W-1:0]   i_push_idx,
    input  wire fws_pkg::t_seg      i_push_seg,
    input  wire logic               i_go,
    input  wire logic [POS_W-1:0]   i_count,
    output logic                    o_idle,
    fws_out_if.source               o_out
);

    fws_pkg::t_seg      r_path_mem [MAX_LEN];

    logic [POS_W-1:0]   r_left;
    logic               r_pend;
    fws_pkg::t_seg      r_rd_seg;
    logic               r_rd_last;
    logic               r_out_vld;
    fws_pkg::t_out_beat r_out;

    logic               n_take;
    logic               n_issue;
    logic [POS_W-1:0]   n_left_m1;

    assign n_take    = r_out_vld && o_out.ready;
    assign n_issue   = (r_left != '0) && !r_pend && (!r_out_vld || n_take);
    assign n_left_m1 = r_left - POS_W'(1);

    // The segments were pushed from the sentence end backward, so they pop
    // from the top of the stack; the one pushed first closes the sentence.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_path_mem[i_push_idx] <= i_push_seg;
        end
        if (n_issue) begin
            r_rd_seg  <= r_path_mem[n_left_m1[IDX_W-1:0]];
            r_rd_last <= (r_left == POS_W'(1));
        end
        if (r_pend) begin
            r_out <= '{seg_start: r_rd_seg.start, seg_len: r_rd_seg.len,
                       seg_token: r_rd_seg.token, last: r_rd_last};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left    <= '0;
            r_pend    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_pend <= n_issue;
            if (i_go) begin
                r_left <= i_count;
            end else if (n_issue) begin
                r_left <= n_left_m1;
            end
            if (r_pend) begin
                r_out_vld <= 1'b1;
            end else if (n_take) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_idle      = (r_left == '0) && !r_pend;
    assign o_out.valid = r_out_vld;
    assign o_out.data  = r_out;

endmodule
`default_nettype wire

// ===== design/fewest_words_segmenter.sv =====
// Top level of the fewest-words segmenter: sequencer, position store and path stack.
//
// The block splits a sentence into the fewest dictionary words. Lookups are
// done upstream; each input beat on i_in is either a candidate edge (start,
// length, found flag, token) or a finish command carrying the sentence length.
// Edges should arrive in ascending start order; each is applied to the store
// as it stands when it arrives.
//
// For an edge, the accept cycle reads the word counts at its start and end
// from the count memory, and the next cycle compares and writes back.
// An edge gives no output beat.
// A finish walks the back-pointers one position per cycle out of the link
// memory, whose read is registered, pushing the segments onto a path stack.
// It then plays them out on o_out in forward order, reading the next segment
// from the stack only once the last read has reached the output register;
// the last beat is marked by last. A finish with a bad length or a broken path
// gives no beats. In every case the store is cleared through its valid bits.
// The next item is taken once the last segment has left the path stack; the
// final beat may still wait in the output register. If the receiver stalls,
// the output register holds its beat and the play-out pauses.
// Reset is synchronous and active low; it empties the store, the path stack
// and the output register at once.
`timescale 1ns / 1ps
`default_nettype none
module fewest_words_segmenter #(
    parameter int MAX_LEN = fws_pkg::MAX_LEN_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    fws_in_if.sink      i_in,
    fws_out_if.source   o_out
);

    localparam int POS_W   = $clog2(MAX_LEN + 1);
    localparam int IDX_W   = $clog2(MAX_LEN);
    localparam int LEN_W   = fws_pkg::LEN_W;
    localparam int START_W = fws_pkg::START_W;

    fws_pkg::t_state     r_state;
    fws_pkg::t_state     n_state;
    logic [POS_W-1:0]    r_pos;
    logic [POS_W-1:0]    r_n;

    fws_pkg::t_store_ctl n_ctl;
    logic [POS_W-1:0]    n_walk_addr;
    fws_pkg::t_link      lnk;
    logic                n_push;
    fws_pkg::t_seg       n_push_seg;
    logic                n_path_go;
    logic                path_idle;
    logic                n_ready;

    logic                n_accept;
    logic                n_is_edge;
    logic                n_slen_bad;
    logic                n_broken;
    logic [LEN_W-1:0]    n_diff;
    logic [POS_W-1:0]    n_npos;

    assign n_accept   = i_in.valid && n_ready;
    assign n_is_edge  = (i_in.data.func == fws_pkg::FUNC_EDGE);
    assign n_slen_bad = (i_in.data.sentence_len == '0)
                     || (i_in.data.sentence_len > LEN_W'(MAX_LEN));

    // A missing back-pointer reads as length zero; a length beyond the
    // current position would step past the sentence start.
    assign n_broken   = (lnk.len == '0) || (lnk.len > LEN_W'(r_pos));
    assign n_diff     = LEN_W'(r_pos) - lnk.len;
    assign n_npos     = n_diff[POS_W-1:0];
    assign n_push_seg = '{start: n_diff[START_W-1:0], len: lnk.len, token: lnk.token};

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            fws_pkg::S_IDLE: begin
                if (n_accept) begin
                    if (n_is_edge) begin
                        n_state = fws_pkg::S_EDGE;
                    end else if (!n_slen_bad) begin
                        n_state = fws_pkg::S_WALK;
                    end
                end
            end
            fws_pkg::S_EDGE: begin
                n_state = fws_pkg::S_IDLE;
            end
            fws_pkg::S_WALK: begin
                if (n_broken) begin
                    n_state = fws_pkg::S_IDLE;
                end else if (n_npos == '0) begin
                    n_state = fws_pkg::S_EMIT;
                end
            end
            fws_pkg::S_EMIT: begin
                if (path_idle) begin
                    n_state = fws_pkg::S_IDLE;
                end
            end
            default: n_state = fws_pkg::S_IDLE;
        endcase
    end

    // Outputs of the sequencer.
    always_comb begin
        n_ready     = 1'b0;
        n_ctl       = '0;
        n_walk_addr = '0;
        n_push      = 1'b0;
        n_path_go   = 1'b0;
        unique case (r_state)
            fws_pkg::S_IDLE: begin
                n_ready = 1'b1;
                if (i_in.valid) begin
                    if (n_is_edge) begin
                        n_ctl.edge_go = 1'b1;
                    end else if (n_slen_bad) begin
                        n_ctl.clear = 1'b1;
                    end else begin
                        n_ctl.walk_rd = 1'b1;
                        n_walk_addr   = POS_W'(i_in.data.sentence_len);
                    end
                end
            end
            fws_pkg::S_EDGE: begin
            end
            fws_pkg::S_WALK: begin
                if (n_broken) begin
                    n_ctl.clear = 1'b1;
                end else begin
                    n_push = 1'b1;
                    if (n_npos == '0) begin
                        n_ctl.clear = 1'b1;
                        n_path_go   = 1'b1;
                    end else begin
                        n_ctl.walk_rd = 1'b1;
                        n_walk_addr   = n_npos;
                    end
                end
            end
            fws_pkg::S_EMIT: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fws_pkg::S_IDLE;
            r_pos   <= '0;
            r_n     <= '0;
        end else begin
            r_state <= n_state;
            if (n_ctl.walk_rd) begin
                r_pos <= n_walk_addr;
            end
            if (r_state == fws_pkg::S_IDLE) begin
                r_n <= '0;
            end else if (n_push) begin
                r_n <= r_n + POS_W'(1);
            end
        end
    end

    assign i_in.ready = n_ready;

    fws_store #(
        .MAX_LEN (MAX_LEN)
    ) u_store (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (n_ctl),
        .i_beat      (i_in.data),
        .i_walk_addr (n_walk_addr),
        .o_link      (lnk)
    );

    fws_path #(
        .MAX_LEN (MAX_LEN)
    ) u_path (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (n_push),
        .i_push_idx (r_n[IDX_W-1:0]),
        .i_push_seg (n_push_seg),
        .i_go       (n_path_go),
        .i_count    (r_n + POS_W'(1)),
        .o_idle     (path_idle),
        .o_out      (o_out)
    );

endmodule
`default_nettype wire
